// File: src/gsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_pkg
// Shared types, constants and helpers of the 5x5 gaussian smoothing unit.
// ----------------------------------------------------------------------------
package gsm_pkg;

    // store geometry
    localparam int MAX_W  = 1024;
    localparam int KS     = 5;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 16;
    localparam int CFGW_W = 11;
    localparam int CFG_DW = 16;

    // decoupling queue
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // datapath widths
    localparam int RSUM_W = 14;
    localparam int SUM_W  = 16;
    localparam int PROD_W = 32;

    // divide by 159: multiply by reciprocal, exact for all sums up to 255*159
    localparam logic [SUM_W-1:0] DIV_M  = 16'd52759;
    localparam int               DIV_SH = 23;

    // reset values of the size registers
    localparam logic [CFGW_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [ROW_W-1:0]  HEIGHT_RST = 16'd480;

    // register indexes
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // kernel weights, row major
    localparam logic [3:0] KERN [KS*KS] = '{
        4'd2, 4'd4,  4'd5,  4'd4,  4'd2,
        4'd4, 4'd9,  4'd12, 4'd9,  4'd4,
        4'd5, 4'd12, 4'd15, 4'd12, 4'd5,
        4'd4, 4'd9,  4'd12, 4'd9,  4'd4,
        4'd2, 4'd4,  4'd5,  4'd4,  4'd2
    };

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       frame_start;
    } gsm_pix_t;

    typedef struct packed {
        logic [7:0]       smoothed_value;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             last_of_run;
    } gsm_res_t;

    // one column of the five line banks
    typedef logic [KS-1:0][7:0] gsm_col_t;

    // one queued column with its output schedule
    typedef struct packed {
        gsm_col_t         col;
        logic [ROW_W-1:0] row;
        logic [2:0]       rm;
        logic [2:0]       rsat;
        logic [COL_W-1:0] col_idx;
        logic             first_col;
        logic             emit;
        logic [1:0]       d_hi;
        logic [1:0]       d_lo;
        logic [1:0]       k_lo;
        logic [1:0]       k_hi;
    } gsm_job_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } gsm_qstat_t;

    // bank holding kernel row i of output row (row - d), edges clamped
    function automatic logic [2:0] bank_sel(input logic [2:0] rm, input logic [2:0] rsat,
                                            input logic [1:0] d, input int i);
        int o;
        int v;
        o = i - 2 - int'(d);
        if (o > 0)
            o = 0;
        if (int'(rsat) + o < 0)
            v = 0;
        else
        begin
            v = int'(rm) + KS + o;
            if (v >= KS)
                v = v - KS;
        end
        return 3'(v);
    endfunction

    // window slot of kernel column j at column offset k, right edge clamped
    function automatic logic [2:0] win_idx(input int j, input logic [1:0] k);
        int t;
        t = j + int'(k);
        if (t > KS - 1)
            t = KS - 1;
        return 3'(t);
    endfunction

endpackage
`default_nettype wire

// File: src/gsm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_queue
// Short fifo of column jobs between the front and the back.
// ----------------------------------------------------------------------------
module gsm_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  gsm_pkg::gsm_job_t   push_data,
    input  wire                 pop,
    output gsm_pkg::gsm_job_t   head,
    output gsm_pkg::gsm_qstat_t qstat
);
    import gsm_pkg::*;

    gsm_job_t            store_reg [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign head        = store_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// File: src/gsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_front
// Takes pixel beats, tracks position, writes the line banks and queues one
// column job per pixel with its output schedule.
// ----------------------------------------------------------------------------
module gsm_front (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           pix_valid,
    output logic                          pix_stall,
    input  gsm_pkg::gsm_pix_t             pix_data,
    input  wire                           cfg_we,
    input  wire [0:0]                     cfg_index,
    input  wire [gsm_pkg::CFG_DW-1:0]     cfg_data,
    input  gsm_pkg::gsm_qstat_t           qstat,
    output logic                          q_push,
    output gsm_pkg::gsm_job_t             q_entry
);
    import gsm_pkg::*;

    logic [CFGW_W-1:0] width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [2:0]        rm_reg;
    logic [2:0]        rm_next;
    logic              f1_valid_reg;
    gsm_job_t          f1_reg;
    logic [7:0]        f1_pix_reg;
    logic [7:0]        rd_reg [KS];

    logic [CFGW_W-1:0] w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic              accept;
    logic              restart;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [2:0]        cur_rm;
    logic [CFGW_W-1:0] col_inc;
    logic [ROW_W:0]    row_inc;
    logic              tail_col;
    logic              tail_row;
    gsm_job_t          meta;

    // effective frame size
    always_comb
    begin
        if (width_reg == '0)
            w_eff = CFGW_W'(1);
        else if (width_reg > CFGW_W'(MAX_W))
            w_eff = CFGW_W'(MAX_W);
        else
            w_eff = width_reg;
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    // room for the beat in flight plus this one
    assign pix_stall = ({1'b0, qstat.count} + {{QCNT_W{1'b0}}, f1_valid_reg})
                       >= (QCNT_W + 1)'(Q_DEPTH);
    assign accept    = pix_valid && !pix_stall;

    // position of this pixel and of the next one
    always_comb
    begin
        restart  = pix_data.frame_start || ({1'b0, col_reg} >= w_eff) || (row_reg >= h_eff);
        cur_row  = restart ? '0 : row_reg;
        cur_col  = restart ? '0 : col_reg;
        cur_rm   = restart ? '0 : rm_reg;
        col_inc  = {1'b0, cur_col} + 1'b1;
        row_inc  = {1'b0, cur_row} + 1'b1;
        tail_col = col_inc >= w_eff;
        tail_row = row_inc >= {1'b0, h_eff};
        row_next = cur_row;
        col_next = col_inc[COL_W-1:0];
        rm_next  = cur_rm;
        if (tail_col)
        begin
            col_next = '0;
            if (tail_row)
            begin
                row_next = '0;
                rm_next  = '0;
            end
            else
            begin
                row_next = row_inc[ROW_W-1:0];
                rm_next  = (cur_rm == 3'(KS - 1)) ? '0 : cur_rm + 1'b1;
            end
        end
    end

    // output schedule of this column
    always_comb
    begin
        meta           = '0;
        meta.row       = cur_row;
        meta.rm        = cur_rm;
        meta.rsat      = (cur_row > ROW_W'(7)) ? 3'd7 : cur_row[2:0];
        meta.col_idx   = cur_col;
        meta.first_col = (cur_col == '0);
        meta.emit      = (tail_row || cur_row >= ROW_W'(2)) && (tail_col || cur_col >= COL_W'(2));
        meta.d_hi      = 2'd2;
        meta.d_lo      = 2'd2;
        meta.k_lo      = 2'd0;
        meta.k_hi      = 2'd0;
        if (tail_row)
        begin
            meta.d_hi = (cur_row >= ROW_W'(2)) ? 2'd2 : cur_row[1:0];
            meta.d_lo = 2'd0;
        end
        if (tail_col)
        begin
            meta.k_lo = (cur_col >= COL_W'(2)) ? 2'd0 : 2'd2 - cur_col[1:0];
            meta.k_hi = 2'd2;
        end
    end

    // size registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
            row_reg      <= '0;
            col_reg      <= '0;
            rm_reg       <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[CFGW_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                endcase
            end
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                rm_reg  <= rm_next;
            end
            f1_valid_reg <= accept;
        end
    end

    // job fields held while the bank read completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_reg     <= meta;
            f1_pix_reg <= pix_data.pixel_value;
        end
    end

    // line banks, one per row modulo five
    for (genvar b = 0; b < KS; b++)
    begin : g_bank
        logic [7:0] mem [MAX_W];

        always_ff @(posedge clk)
        begin
            if (accept && cur_rm == 3'(b))
                mem[cur_col] <= pix_data.pixel_value;
        end

        always_ff @(posedge clk)
        begin
            if (accept)
                rd_reg[b] <= mem[cur_col];
        end
    end

    // push the column, new pixel bypassing its own bank
    always_comb
    begin
        q_push  = f1_valid_reg;
        q_entry = f1_reg;
        for (int b = 0; b < KS; b++)
            q_entry.col[b] = (f1_reg.rm == 3'(b)) ? f1_pix_reg : rd_reg[b];
    end

endmodule
`default_nettype wire

// File: src/gsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsm_back
// Slides the 5x5 window over queued columns, issues the scheduled outputs and
// computes the weighted sum and the divide by 159 in a short pipeline.
// ----------------------------------------------------------------------------
module gsm_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  gsm_pkg::gsm_job_t   head,
    input  gsm_pkg::gsm_qstat_t qstat,
    output logic                q_pop,
    output logic                res_valid,
    input  wire                 res_stall,
    output gsm_pkg::gsm_res_t   res_data
);
    import gsm_pkg::*;

    logic              job_active_reg;
    gsm_job_t          job_reg;
    gsm_col_t          win_reg [KS];
    logic [1:0]        d_reg;
    logic [1:0]        k_reg;

    logic              s1_valid_reg;
    logic [RSUM_W-1:0] s1_rsum_reg [KS];
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_last_reg;

    logic              s2_valid_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic [ROW_W-1:0]  s2_row_reg;
    logic [COL_W-1:0]  s2_col_reg;
    logic              s2_last_reg;

    logic              res_valid_reg;
    gsm_res_t          res_reg;

    logic              adv;
    logic              issue_last;
    logic [RSUM_W-1:0] rsum [KS];
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;

    assign adv        = !res_valid_reg || !res_stall;
    assign issue_last = (d_reg == job_reg.d_lo) && (k_reg == job_reg.k_hi);
    assign q_pop      = adv && !qstat.empty && (!job_active_reg || issue_last);
    assign res_valid  = res_valid_reg;
    assign res_data   = res_reg;

    // job sequencer: rows outer, columns inner
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            job_active_reg <= 1'b0;
        else if (q_pop)
            job_active_reg <= head.emit;
        else if (adv && job_active_reg && issue_last)
            job_active_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= head;
            d_reg   <= head.d_hi;
            k_reg   <= head.k_lo;
            if (head.first_col)
            begin
                for (int s = 0; s < KS; s++)
                    win_reg[s] <= head.col;
            end
            else
            begin
                for (int s = 0; s < KS - 1; s++)
                    win_reg[s] <= win_reg[s+1];
                win_reg[KS-1] <= head.col;
            end
        end
        else if (adv && job_active_reg && !issue_last)
        begin
            if (k_reg == job_reg.k_hi)
            begin
                k_reg <= job_reg.k_lo;
                d_reg <= d_reg - 1'b1;
            end
            else
                k_reg <= k_reg + 1'b1;
        end
    end

    // kernel row sums of the clamped taps
    always_comb
    begin
        for (int i = 0; i < KS; i++)
        begin
            rsum[i] = '0;
            for (int j = 0; j < KS; j++)
                rsum[i] = rsum[i]
                        + RSUM_W'(win_reg[win_idx(j, k_reg)]
                                         [bank_sel(job_reg.rm, job_reg.rsat, d_reg, i)])
                        * RSUM_W'(KERN[i*KS+j]);
        end
    end

    // total and reciprocal multiply
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < KS; i++)
            sum = sum + SUM_W'(s1_rsum_reg[i]);
        prod = PROD_W'(s2_sum_reg) * PROD_W'(DIV_M);
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= job_active_reg;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rsum_reg <= rsum;
            s1_row_reg  <= job_reg.row - ROW_W'(d_reg);
            s1_col_reg  <= job_reg.col_idx - COL_W'(2) + COL_W'(k_reg);
            s1_last_reg <= issue_last;

            s2_sum_reg  <= sum;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_last_reg <= s1_last_reg;

            res_reg.smoothed_value <= prod[DIV_SH +: 8];
            res_reg.out_row        <= s2_row_reg;
            res_reg.out_col        <= s2_col_reg;
            res_reg.last_of_run    <= s2_last_reg;
        end
    end

endmodule
`default_nettype wire

// File: src/gaussian_smooth_5x5_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_smooth_5x5_unit
// Streaming 5x5 gaussian smoothing (kernel sum 159) of raster 8-bit pixels.
//
//   channel   beat         handshake            meaning
//   pix       gsm_pix_t    pix_valid/pix_stall  raster pixel, frame start
//   res       gsm_res_t    res_valid/res_stall  smoothed pixel, row, column
//   cfg       16-bit data  cfg_we, cfg_index    width, height registers
//
// One pixel beat per cycle unless pix_stall; a result passes f1, the queue,
// window, s1, s2 and result registers; one result per cycle from the window
// sequencer unless res_stall holds it. A row or frame's last pixel gives
// up to three or nine results, holding the queue, which can stall pixels.
// Reset clears counters and pipeline; line banks need no clearing.
// A stalled result holds the whole back pipeline; the front keeps taking
// pixels until the four-entry queue is full.
// ----------------------------------------------------------------------------
module gaussian_smooth_5x5_unit (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       pix_valid,
    output logic                      pix_stall,
    input  gsm_pkg::gsm_pix_t         pix_data,
    output logic                      res_valid,
    input  wire                       res_stall,
    output gsm_pkg::gsm_res_t         res_data,
    input  wire                       cfg_we,
    input  wire [0:0]                 cfg_index,
    input  wire [gsm_pkg::CFG_DW-1:0] cfg_data
);
    import gsm_pkg::*;

    logic       q_push;
    logic       q_pop;
    gsm_job_t   q_entry;
    gsm_job_t   q_head;
    gsm_qstat_t qstat;

    // position tracking and line banks
    gsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // column jobs in flight
    gsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .pop       (q_pop),
        .head      (q_head),
        .qstat     (qstat)
    );

    // window and arithmetic
    gsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .qstat     (qstat),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // queue never written when full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && qstat.count == QCNT_W'(Q_DEPTH)))
        else $error("job queue overflow");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && qstat.empty))
        else $error("job queue underflow");

    // every accepted pixel beat becomes a queued job next cycle
    a_beat_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall) |=> q_push)
        else $error("accepted pixel not queued");

endmodule
`default_nettype wire

// File: bench/gaussian_smooth_5x5_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_smooth_5x5_unit_test
// Self-checking bench for the 5x5 gaussian smoothing unit. A behavioral
// line-store predictor computes every smoothed pixel as beats are accepted;
// results are matched in order, field by field, under random gaps and stalls.
// ----------------------------------------------------------------------------
module gaussian_smooth_5x5_unit_test;
    import gsm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 30;
    localparam int RAND_ITEMS  = 330;

    // kernel weights, row major
    localparam int GWT [25] = '{2, 4, 5, 4, 2,
                                4, 9, 12, 9, 4,
                                5, 12, 15, 12, 5,
                                4, 9, 12, 9, 4,
                                2, 4, 5, 4, 2};

    typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e  kind;
        logic [0:0] idx;
        logic [15:0] data;
        logic [7:0] pix;
        logic       fs;
        bit         has_exp;
        logic [7:0] exp_val;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      pix_valid;
    logic      pix_stall;
    gsm_pix_t  pix_data;
    logic      res_valid;
    logic      res_stall;
    gsm_res_t  res_data;
    logic      cfg_we;
    logic [0:0] cfg_index;
    logic [15:0] cfg_data;

    gsm_res_t  smooth_q [$];
    stim_row_t stim_tbl [$];
    int        err_cnt;
    int        cycles;
    bit        hold_req;
    bit        calm;

    // predictor state
    logic [7:0]  px_store [KS*MAX_W];
    int unsigned row_cnt;
    int unsigned col_cnt;
    int unsigned img_w;
    int unsigned img_h;

    gaussian_smooth_5x5_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // weighted 5x5 sum at (r, c) with edge clamping
    function automatic int gauss_at(input int r, input int c, input int w, input int h);
        int sum;
        int tr;
        int tc;
        sum = 0;
        for (int dy = -2; dy <= 2; dy++)
        begin
            tr = r + dy;
            if (tr < 0) tr = 0;
            if (tr > h - 1) tr = h - 1;
            for (int dx = -2; dx <= 2; dx++)
            begin
                tc = c + dx;
                if (tc < 0) tc = 0;
                if (tc > w - 1) tc = w - 1;
                sum += int'(px_store[(tr % KS) * MAX_W + tc]) * GWT[(dy + 2) * 5 + dx + 2];
            end
        end
        return sum / 159;
    endfunction

    // take one pixel, queue the smoothed pixels it completes; returns count
    function automatic int predict_smooth(input logic [7:0] pix, input logic fs);
        int w;
        int h;
        int rr;
        int cc;
        int rlo;
        int rhi;
        int clo;
        int chi;
        int n;
        gsm_res_t o;
        w = (img_w < 1) ? 1 : (img_w > MAX_W) ? MAX_W : int'(img_w);
        h = (img_h == 0) ? 1 : int'(img_h);
        n = 0;
        if (fs || col_cnt >= w || row_cnt >= h)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        rr = row_cnt;
        cc = col_cnt;
        px_store[(rr % KS) * MAX_W + cc] = pix;
        if (rr + 1 < h) begin rlo = rr - 2; rhi = rr - 2; end
        else begin rlo = (rr >= 2) ? rr - 2 : 0; rhi = rr; end
        if (cc + 1 < w) begin clo = cc - 2; chi = cc - 2; end
        else begin clo = (cc >= 2) ? cc - 2 : 0; chi = cc; end
        if (rlo >= 0 && clo >= 0)
        begin
            for (int r = rlo; r <= rhi; r++)
            begin
                for (int c = clo; c <= chi; c++)
                begin
                    o.smoothed_value = 8'(gauss_at(r, c, w, h));
                    o.out_row        = 16'(r);
                    o.out_col        = 10'(c);
                    o.last_of_run    = (r == rhi && c == chi);
                    smooth_q.push_back(o);
                    n++;
                end
            end
        end
        col_cnt++;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
        end
        return n;
    endfunction

    // random gap length, mostly short, a few long
    function automatic int gap_len();
        if (calm) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // offer one pixel beat and wait until it is taken
    task automatic send_pix(input logic [7:0] pix, input logic fs, input bit has_exp,
                            input logic [7:0] exp_val);
        int gap;
        int n;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= '{pixel_value: pix, frame_start: fs};
        do @(posedge clk); while (pix_stall);
        n = predict_smooth(pix, fs);
        if (has_exp)
        begin
            for (int i = smooth_q.size() - n; i < smooth_q.size(); i++)
            begin
                if (smooth_q[i].smoothed_value !== exp_val)
                begin
                    $display("%0t: smoothed_value expected %0d actual %0d (table)", $time,
                             exp_val, smooth_q[i].smoothed_value);
                    err_cnt++;
                end
            end
        end
    endtask

    // drop valid, drain all results, let the pipeline settle
    task automatic drain();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (smooth_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            img_w = data & 16'h07ff;
        else
            img_h = data;
    endtask

    function automatic void add_pix(input logic [7:0] pix, input logic fs, input bit has_exp,
                                    input logic [7:0] exp_val);
        stim_tbl.push_back('{ROW_PIX, REG_IMAGE_WIDTH, 16'd0, pix, fs, has_exp, exp_val});
    endfunction

    function automatic void add_cfg(input logic [0:0] idx, input logic [15:0] data);
        stim_tbl.push_back('{ROW_CFG, idx, data, 8'd0, 1'b0, 1'b0, 8'd0});
    endfunction

    // result side stall pattern, with one long hold on request
    initial
    begin
        int n;
        res_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                res_stall <= !calm && ($urandom_range(0, 3) == 0);
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24)
                                                 : $urandom_range(1, 3);
                repeat (n) @(negedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        gsm_res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (smooth_q.size() == 0)
            begin
                $display("%0t: unexpected beat, actual %p", $time, res_data);
                err_cnt++;
            end
            else
            begin
                e = smooth_q.pop_front();
                if (res_data.smoothed_value !== e.smoothed_value)
                begin
                    $display("%0t: smoothed_value expected %0d actual %0d", $time,
                             e.smoothed_value, res_data.smoothed_value);
                    err_cnt++;
                end
                if (res_data.out_row !== e.out_row)
                begin
                    $display("%0t: out_row expected %0d actual %0d", $time,
                             e.out_row, res_data.out_row);
                    err_cnt++;
                end
                if (res_data.out_col !== e.out_col)
                begin
                    $display("%0t: out_col expected %0d actual %0d", $time,
                             e.out_col, res_data.out_col);
                    err_cnt++;
                end
                if (res_data.last_of_run !== e.last_of_run)
                begin
                    $display("%0t: last_of_run expected %0d actual %0d", $time,
                             e.last_of_run, res_data.last_of_run);
                    err_cnt++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int w;
        int h;
        int sent;
        int len;
        err_cnt   = 0;
        cycles    = 0;
        hold_req  = 1'b0;
        calm      = 1'b0;
        rst_n     = 1'b0;
        pix_valid = 1'b0;
        pix_data  = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        row_cnt   = 0;
        col_cnt   = 0;
        img_w     = 640;
        img_h     = 480;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset sizes give nothing yet; shrinking restarts the counters
        add_pix(8'h00, 1'b1, 1'b0, 8'd0);
        add_pix(8'hff, 1'b0, 1'b0, 8'd0);
        add_pix(8'h55, 1'b0, 1'b0, 8'd0);
        add_pix(8'haa, 1'b0, 1'b0, 8'd0);
        add_cfg(REG_IMAGE_WIDTH, 16'd3);
        add_cfg(REG_IMAGE_HEIGHT, 16'd3);
        // flat frames smooth to themselves
        for (int i = 0; i < 9; i++) add_pix(8'hff, 1'b0, 1'b1, 8'hff);
        for (int i = 0; i < 9; i++) add_pix(8'h00, i == 0, 1'b1, 8'h00);
        // zero sizes act as one pixel
        add_cfg(REG_IMAGE_WIDTH, 16'd0);
        add_cfg(REG_IMAGE_HEIGHT, 16'd0);
        add_pix(8'd200, 1'b1, 1'b1, 8'd200);
        add_pix(8'd37, 1'b0, 1'b1, 8'd37);
        foreach (stim_tbl[i])
        begin
            if (stim_tbl[i].kind == ROW_CFG)
                write_reg(stim_tbl[i].idx, stim_tbl[i].data);
            else
                send_pix(stim_tbl[i].pix, stim_tbl[i].fs, stim_tbl[i].has_exp,
                         stim_tbl[i].exp_val);
        end

        // widest row, oversized width register clamps to the store width
        write_reg(REG_IMAGE_WIDTH, 16'h07ff);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        calm = 1'b1;
        for (int i = 0; i < MAX_W; i++) send_pix(8'($urandom), i == 0, 1'b0, 8'd0);
        calm = 1'b0;
        write_reg(REG_IMAGE_WIDTH, 16'd1024);
        for (int i = 0; i < 12; i++) send_pix(8'($urandom), i == 0, 1'b0, 8'd0);
        // tallest frame, one pixel per row
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        write_reg(REG_IMAGE_HEIGHT, 16'hffff);
        for (int i = 0; i < 20; i++) send_pix(8'($urandom), i == 0, 1'b0, 8'd0);

        // random frames of small size
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            w = $urandom_range(0, 12);
            h = $urandom_range(0, 8);
            write_reg(REG_IMAGE_WIDTH, 16'(w));
            write_reg(REG_IMAGE_HEIGHT, 16'(h));
            if (w < 1) w = 1;
            if (h < 1) h = 1;
            calm = ($urandom_range(0, 4) == 0);
            len = w * h;
            // most frames whole, some cut short or restarted
            if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
            for (int i = 0; i < len; i++)
            begin
                if (sent == RAND_ITEMS / 2) hold_req = 1'b1;
                send_pix(8'($urandom), i == 0 || $urandom_range(0, 59) == 0, 1'b0, 8'd0);
                sent++;
            end
            // a second frame back to back at the same size
            if ($urandom_range(0, 2) == 0)
            begin
                for (int i = 0; i < w * h; i++)
                begin
                    if (sent == RAND_ITEMS / 2) hold_req = 1'b1;
                    send_pix(8'($urandom), i == 0, 1'b0, 8'd0);
                    sent++;
                end
            end
        end

        drain();
        while (hold_req) @(posedge clk);
        while (smooth_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
src/gsm_pkg.sv
src/gsm_queue.sv
src/gsm_front.sv
src/gsm_back.sv
src/gaussian_smooth_5x5_unit.sv
bench/gaussian_smooth_5x5_unit_test.sv
